[src/text_transcoder_to_utf8_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the transcoder RTL
// ---------------------------------------------------------------------------
`ifndef TEXT_TRANSCODER_TO_UTF8_CORE_MACROS_SVH
`define TEXT_TRANSCODER_TO_UTF8_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define TT8_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tt8 same-cycle check failed");

// Next-cycle implication
`define TT8_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tt8 next-cycle check failed");

`endif

[src/tt8_pkg.sv]
// ---------------------------------------------------------------------------
// tt8_pkg
// Types, codes and the per-byte encoder of the UTF-8 transcoder.
// ---------------------------------------------------------------------------
package tt8_pkg;

    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_LATIN1 = 2'd1;
    localparam logic [1:0] MODE_UTF16  = 2'd2;

    localparam int         NUM_REGS    = 1;
    localparam logic       REG_MODE    = 1'b0;

    localparam logic [15:0] SURR_LO    = 16'hD800;
    localparam logic [15:0] SURR_HI    = 16'hDFFF;
    localparam logic [15:0] TWO_MAX    = 16'h07FF;
    localparam logic [15:0] ONE_MAX    = 16'h007F;
    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  C1_MAX     = 8'h9F;
    localparam logic [7:0]  LATIN_C2   = 8'hC2;
    localparam logic [7:0]  LATIN_C3   = 8'hC3;
    localparam logic [7:0]  LATIN_HI   = 8'hBF;
    localparam logic [7:0]  CONT_MASK  = 8'h3F;
    localparam logic [7:0]  CONT_MARK  = 8'h80;

    // Bytes produced by one request; cnt of zero means nothing to send
    typedef struct packed {
        logic [1:0]      cnt;
        logic            bad;
        logic [2:0][7:0] data;
    } t_enc;

    function automatic t_enc encode(input logic [1:0] mode, input logic have_low,
                                    input logic [7:0] held, input logic [7:0] b);
        t_enc        e;
        logic [15:0] cu;
        e  = '0;
        cu = {b, held};
        case (mode)
            MODE_LATIN1: begin
                if (b <= ONE_MAX[7:0]) begin
                    e.cnt     = 2'd1;
                    e.data[0] = b;
                end else if (b <= C1_MAX) begin
                    e.cnt = 2'd1;
                    e.bad = 1'b1;
                end else begin
                    e.cnt     = 2'd2;
                    e.data[0] = (b > LATIN_HI) ? LATIN_C3 : LATIN_C2;
                    e.data[1] = CONT_MARK | (b & CONT_MASK);
                end
            end
            MODE_UTF16: begin
                if (!have_low) begin
                    e.cnt = 2'd0;
                end else if (cu >= SURR_LO && cu <= SURR_HI) begin
                    e.cnt = 2'd1;
                    e.bad = 1'b1;
                end else if (cu <= ONE_MAX) begin
                    e.cnt     = 2'd1;
                    e.data[0] = cu[7:0];
                end else if (cu <= TWO_MAX) begin
                    e.cnt     = 2'd2;
                    e.data[0] = LEAD2 | {3'b000, cu[10:6]};
                    e.data[1] = CONT_MARK | {2'b00, cu[5:0]};
                end else begin
                    e.cnt     = 2'd3;
                    e.data[0] = LEAD3 | {4'b0000, cu[15:12]};
                    e.data[1] = CONT_MARK | {2'b00, cu[11:6]};
                    e.data[2] = CONT_MARK | {2'b00, cu[5:0]};
                end
            end
            default: begin
                e.cnt     = 2'd1;
                e.data[0] = b;
            end
        endcase
        return e;
    endfunction

endpackage

[src/text_transcoder_to_utf8_core.sv]
// Request bytes are held in the byte buffer, then registered one by one for output.
// Throughput: one output byte per cycle unless i_stall; the input side stalls until
// the single-byte output register has taken the request's last byte from the buffer.
// A UTF-16 low byte is accepted into the pairing state and produces nothing.
// Reset: synchronous, active low; mode returns to passthrough, pending low byte dropped.
// ---------------------------------------------------------------------------
// text_transcoder_to_utf8_core
// Converts passthrough, Latin-1 or UTF-16LE byte streams to UTF-8 bytes.
// ---------------------------------------------------------------------------
`include "text_transcoder_to_utf8_core_macros.svh"

module text_transcoder_to_utf8_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_in_run,
    output logic        o_bad_input
);
    import tt8_pkg::*;

    logic [1:0] r_mode;
    logic [7:0] r_held;
    logic       r_have;
    t_enc       r_q;
    logic       r_q_valid;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_bad;

    t_enc       enc;
    logic       cfg_wr;
    logic       in_acc;
    logic       take_out;
    logic       move;
    logic       q_last;
    logic       q_done;
    logic [1:0] n_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_MODE);
    assign prdata  = (paddr[2] == REG_MODE) ? {30'd0, r_mode} : 32'd0;

    assign enc      = encode(r_mode, r_have, r_held, i_in_byte);
    assign take_out = r_out_valid && !i_stall;
    assign move     = r_q_valid && (!r_out_valid || take_out);
    assign q_last   = (r_idx == (r_q.cnt - 2'd1));
    assign q_done   = move && q_last;
    assign n_idx    = r_idx + 2'd1;
    assign o_stall  = r_q_valid && !q_done;
    assign in_acc   = i_valid && !o_stall;

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_in_run = r_out_last;
    assign o_bad_input   = r_out_bad;

    // Mode register and UTF-16 pairing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
            r_have <= 1'b0;
            r_held <= 8'd0;
        end else if (cfg_wr) begin
            r_mode <= pwdata[1:0];
            r_have <= 1'b0;
            r_held <= 8'd0;
        end else if (in_acc && r_mode == MODE_UTF16) begin
            r_have <= !r_have;
            r_held <= r_have ? 8'd0 : i_in_byte;
        end
    end

    // Byte buffer: hold one request's bytes, advance one per output move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_idx     <= 2'd0;
        end else if (in_acc && enc.cnt != 2'd0) begin
            r_q_valid <= 1'b1;
            r_idx     <= 2'd0;
        end else if (q_done) begin
            r_q_valid <= 1'b0;
        end else if (move) begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && enc.cnt != 2'd0) begin
            r_q <= enc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (take_out) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_byte <= r_q.data[r_idx];
            r_out_last <= q_last;
            r_out_bad  <= r_q.bad;
        end
    end

    `TT8_ASSERT_NOW(a_stall_needs_buf, o_stall, r_q_valid)
    `TT8_ASSERT_NOW(a_idx_in_range, r_q_valid, (r_idx < r_q.cnt))
    `TT8_ASSERT_NEXT(a_move_fills_out, move, o_valid)
    `TT8_ASSERT_NOW(a_bad_form, o_valid && o_bad_input, (o_out_byte == 8'd0) && o_last_in_run)
    `TT8_ASSERT_NEXT(a_low_byte_silent, in_acc && (enc.cnt == 2'd0), !r_q_valid)

endmodule
